/* hw/rtl/rc4ks_pkg.sv */
package rc4ks_pkg;

    localparam int STATE_SIZE      = 256;
    localparam int SW              = 8;
    localparam int KEY_DEPTH_DEF   = 256;
    localparam int KLW             = 9;
    localparam logic [KLW-1:0] KEY_LEN_RST = 9'd16;
    localparam logic [KLW-1:0] KEY_LEN_MAX = 9'd256;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SCHED  = 2'd1;
    localparam logic [1:0] MODE_STREAM = 2'd2;

    typedef logic [SW-1:0] t_byte;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_G_J,
        ST_G_WI,
        ST_G_OUT,
        ST_K_I,
        ST_K_J,
        ST_K_WI,
        ST_K_WJ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  clear;
        logic  wr_en;
        t_byte wr_addr;
        t_byte wr_data;
        t_byte rd_addr;
    } t_perm_ctl;

endpackage

/* hw/rtl/rc4ks_perm_mem.sv */
module rc4ks_perm_mem
    import rc4ks_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_perm_ctl i_ctl,
    output t_byte     o_rd_data
);

    t_byte                 r_mem [STATE_SIZE];
    logic [STATE_SIZE-1:0] r_written;
    t_byte                 r_rd_data;
    t_byte                 r_rd_addr;
    logic                  r_rd_written;

    // unwritten entries read as their own index
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        r_rd_data <= r_mem[i_ctl.rd_addr];
        r_rd_addr <= i_ctl.rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            r_rd_written <= r_written[i_ctl.rd_addr];
            if (i_ctl.clear) begin
                r_written <= '0;
            end else if (i_ctl.wr_en) begin
                r_written[i_ctl.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : r_rd_addr;

endmodule

/* hw/rtl/rc4ks_key_mem.sv */
module rc4ks_key_mem
    import rc4ks_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF,
    parameter int KAW       = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  logic [KAW-1:0] i_wr_addr,
    input  t_byte          i_wr_data,
    input  logic [KAW-1:0] i_rd_addr,
    output t_byte          o_rd_data
);

    t_byte r_mem [KEY_DEPTH];
    t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/rc4_keystream_generator_top.sv */
// keystream word: G_J, G_WI, then G_OUT loads the result register; next word taken back in IDLE
// key byte load or unused mode: DONE loads the result register; next word taken back in IDLE
// key schedule: K_I, K_J, K_WI, K_WJ per permutation entry, then DONE loads the result
// one item in flight; a finished word may wait in the output register while the next is taken
// synchronous active-low reset: indices zero, key_length 16, permutation reads as identity
// key store holds no defined value after reset
module rc4_keystream_generator_top
    import rc4ks_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [KLW-1:0] i_cfg_data,   // key_length
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [15:0]    i_s_tdata,    // key_byte[7:0], key_index[15:8]
    input  logic [1:0]     i_s_tuser,    // mode[1:0]
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,    // stream_byte[7:0]
    output logic           o_m_tuser     // stream_valid[0]
);

    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    t_state         r_state, n_state;
    logic [KLW-1:0] r_key_len;
    t_byte          r_i, r_j, r_si, r_sj, r_k, r_c;
    logic [KAW-1:0] r_kp;
    logic           r_m_valid;
    t_byte          r_m_byte;
    logic           r_m_flag;

    t_perm_ctl      perm_ctl;
    t_byte          perm_rd;
    t_byte          key_rd;
    logic           s_acc;
    logic           out_space;
    logic           out_load;
    t_byte          out_byte;
    logic           out_flag;
    logic           key_wr;
    logic [KLW-1:0] len_c;
    logic           c_wrap;
    t_byte          sum_t;
    t_byte          j_sched;

    assign s_acc     = i_s_tvalid && o_s_tready;
    assign out_space = !r_m_valid || i_m_tready;
    assign sum_t     = r_si + r_sj;
    assign j_sched   = r_j + perm_rd + key_rd;

    always_comb begin
        if (r_key_len == '0) begin
            len_c = 9'd1;
        end else if (r_key_len > KEY_LEN_MAX) begin
            len_c = KEY_LEN_MAX;
        end else begin
            len_c = r_key_len;
        end
    end

    assign c_wrap = ({1'b0, r_c} + 9'd1) >= len_c;

    rc4ks_perm_mem u_perm_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (perm_ctl),
        .o_rd_data (perm_rd)
    );

    rc4ks_key_mem #(
        .KEY_DEPTH (KEY_DEPTH),
        .KAW       (KAW)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_wr_en   (key_wr),
        .i_wr_addr (i_s_tdata[KAW+7:8]),
        .i_wr_data (i_s_tdata[7:0]),
        .i_rd_addr (r_kp),
        .o_rd_data (key_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    priority if (i_s_tuser == MODE_STREAM) begin
                        n_state = ST_G_J;
                    end else if (i_s_tuser == MODE_SCHED) begin
                        n_state = ST_K_I;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_G_J:   n_state = ST_G_WI;
            ST_G_WI:  n_state = ST_G_OUT;
            ST_G_OUT: n_state = out_space ? ST_IDLE : ST_G_OUT;
            ST_K_I:   n_state = ST_K_J;
            ST_K_J:   n_state = ST_K_WI;
            ST_K_WI:  n_state = ST_K_WJ;
            ST_K_WJ:  n_state = (r_k == t_byte'(STATE_SIZE - 1)) ? ST_DONE : ST_K_I;
            ST_DONE:  n_state = out_space ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_s_tready       = 1'b0;
        key_wr           = 1'b0;
        out_load         = 1'b0;
        out_byte         = '0;
        out_flag         = 1'b0;
        perm_ctl.clear   = 1'b0;
        perm_ctl.wr_en   = 1'b0;
        perm_ctl.wr_addr = r_i;
        perm_ctl.wr_data = perm_rd;
        perm_ctl.rd_addr = r_i + 8'd1;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready     = 1'b1;
                key_wr         = s_acc && (i_s_tuser == MODE_LOAD) &&
                                 ({1'b0, i_s_tdata[15:8]} < 9'(KEY_DEPTH));
                perm_ctl.clear = s_acc && (i_s_tuser == MODE_SCHED);
            end
            ST_G_J: begin
                perm_ctl.rd_addr = r_j + perm_rd;
            end
            ST_G_WI: begin
                perm_ctl.wr_en   = 1'b1;
                perm_ctl.wr_addr = r_i;
                perm_ctl.wr_data = perm_rd;
                perm_ctl.rd_addr = r_si + perm_rd;
            end
            ST_G_OUT: begin
                perm_ctl.wr_en   = 1'b1;
                perm_ctl.wr_addr = r_j;
                perm_ctl.wr_data = r_si;
                perm_ctl.rd_addr = sum_t;
                out_load         = out_space;
                out_flag         = 1'b1;
                // swapped entries are not yet in memory
                priority if (sum_t == r_j) begin
                    out_byte = r_si;
                end else if (sum_t == r_i) begin
                    out_byte = r_sj;
                end else begin
                    out_byte = perm_rd;
                end
            end
            ST_K_I: begin
                perm_ctl.rd_addr = r_k;
            end
            ST_K_J: begin
                perm_ctl.rd_addr = j_sched;
            end
            ST_K_WI: begin
                perm_ctl.wr_en   = 1'b1;
                perm_ctl.wr_addr = r_k;
                perm_ctl.wr_data = perm_rd;
            end
            ST_K_WJ: begin
                perm_ctl.wr_en   = 1'b1;
                perm_ctl.wr_addr = r_j;
                perm_ctl.wr_data = r_si;
            end
            ST_DONE: begin
                out_load = out_space;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_key_len <= KEY_LEN_RST;
            r_i       <= '0;
            r_j       <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_key_len <= i_cfg_data;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc && (i_s_tuser == MODE_STREAM)) begin
                        r_i <= r_i + 8'd1;
                    end else if (s_acc && (i_s_tuser == MODE_SCHED)) begin
                        r_j <= '0;
                    end
                end
                ST_G_J:  r_j <= r_j + perm_rd;
                ST_K_J:  r_j <= j_sched;
                ST_K_WJ: begin
                    if (r_k == t_byte'(STATE_SIZE - 1)) begin
                        r_i <= '0;
                        r_j <= '0;
                    end
                end
                default: begin
                    r_i <= r_i;
                end
            endcase
        end
    end

    // datapath words, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_byte <= out_byte;
            r_m_flag <= out_flag;
        end
        if (r_state == ST_G_J || r_state == ST_K_J) begin
            r_si <= perm_rd;
        end
        if (r_state == ST_G_WI) begin
            r_sj <= perm_rd;
        end
        if (r_state == ST_IDLE) begin
            r_k  <= '0;
            r_c  <= '0;
            r_kp <= '0;
        end else if (r_state == ST_K_WJ) begin
            r_k <= r_k + 8'd1;
            if (c_wrap) begin
                r_c  <= '0;
                r_kp <= '0;
            end else begin
                r_c <= r_c + 8'd1;
                if (r_kp == KAW'(KEY_DEPTH - 1)) begin
                    r_kp <= '0;
                end else begin
                    r_kp <= r_kp + 1'b1;
                end
            end
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_byte;
    assign o_m_tuser   = r_m_flag;

endmodule

/* hw/rtl/rc4ks_checker.sv */
module rc4ks_checker
    import rc4ks_pkg::*;
(
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_cfg_valid,
    input logic           o_cfg_ready,
    input logic [KLW-1:0] i_cfg_data,
    input logic           i_s_tvalid,
    input logic           o_s_tready,
    input logic [15:0]    i_s_tdata,
    input logic [1:0]     i_s_tuser,
    input logic           o_m_tvalid,
    input logic           i_m_tready,
    input logic [7:0]     o_m_tdata,
    input logic           o_m_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // non-keystream results carry zero
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 8'd0)
        else $error("nonzero byte on non-keystream result");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second word taken while busy");

    // reset leaves the block empty and ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready && o_cfg_ready)
        else $error("bad state after reset");

endmodule

bind rc4_keystream_generator_top rc4ks_checker u_rc4ks_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tdata   (i_s_tdata),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);

/* sim/tb_rc4_keystream_generator_top.sv */
module tb_rc4_keystream_generator_top;
    import rc4ks_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 40;

    typedef struct packed {
        logic [1:0] mode;
        t_byte      key_index;
        t_byte      key_byte;
    } t_ks_item;

    typedef struct packed {
        logic  stream_valid;
        t_byte stream_byte;
    } t_ks_word;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [KLW-1:0] i_cfg_data = '0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    logic [15:0]    i_s_tdata = '0;
    logic [1:0]     i_s_tuser = '0;
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    logic [7:0]     o_m_tdata;
    logic           o_m_tuser;

    rc4_keystream_generator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    t_byte          perm [STATE_SIZE];
    t_byte          key_mem [256];
    t_byte          idx_i = '0;
    t_byte          idx_j = '0;
    logic [KLW-1:0] sched_len = KEY_LEN_RST;

    // generator state
    bit             key_set [256];
    logic [KLW-1:0] gen_len = KEY_LEN_RST;
    int             gen_count = 0;

    t_ks_item item_q [$];
    t_ks_word ks_due_q [$];

    int errors = 0;
    int n_items = 0;
    int n_words = 0;
    int n_stream = 0;
    int n_sched = 0;
    int n_load = 0;
    int n_unused = 0;
    int n_cfg = 0;

    function automatic int eff_len(input logic [KLW-1:0] len);
        if (len == 0)
            return 1;
        if (len > 256)
            return 256;
        return int'(len);
    endfunction

    function automatic t_ks_word rc4_advance(input t_ks_item it);
        t_ks_word w;
        int       len;
        int       j;
        t_byte    tmp;
        w = '0;
        case (it.mode)
            MODE_LOAD: begin
                key_mem[it.key_index] = it.key_byte;
            end
            MODE_SCHED: begin
                len = eff_len(sched_len);
                for (int k = 0; k < STATE_SIZE; k++)
                    perm[k] = t_byte'(k);
                j = 0;
                for (int k = 0; k < STATE_SIZE; k++) begin
                    j = (j + int'(perm[k]) + int'(key_mem[(k % len) % 256])) % STATE_SIZE;
                    tmp = perm[k];
                    perm[k] = perm[j];
                    perm[j] = tmp;
                end
                idx_i = '0;
                idx_j = '0;
            end
            MODE_STREAM: begin
                idx_i = idx_i + 8'd1;
                idx_j = idx_j + perm[idx_i];
                tmp = perm[idx_i];
                perm[idx_i] = perm[idx_j];
                perm[idx_j] = tmp;
                tmp = perm[idx_i] + perm[idx_j];
                w.stream_byte = perm[tmp];
                w.stream_valid = 1'b1;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic add_item(input logic [1:0] mode, input int kb, input int ki);
        t_ks_item it;
        it.mode = mode;
        it.key_byte = t_byte'(kb);
        it.key_index = t_byte'(ki);
        if (mode == MODE_LOAD)
            key_set[it.key_index] = 1'b1;
        item_q.insert(item_q.size(), it);
        gen_count++;
    endtask

    // fill any key position the schedule will read before scheduling
    task automatic add_sched();
        for (int k = 0; k < eff_len(gen_len); k++)
            if (!key_set[k])
                add_item(MODE_LOAD, $urandom_range(0, 255), k);
        add_item(MODE_SCHED, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    function automatic int key_pos();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, eff_len(gen_len) - 1);
        return $urandom_range(0, 255);
    endfunction

    task automatic gen_phase(input int budget);
        int stop_at;
        int pick;
        stop_at = gen_count + budget;
        while (gen_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                // rekey then a run of keystream
                repeat ($urandom_range(0, 4))
                    add_item(MODE_LOAD, $urandom_range(0, 255), key_pos());
                add_sched();
                repeat ($urandom_range(4, 30))
                    add_item(MODE_STREAM, $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (pick < 70) begin
                add_item(MODE_STREAM, $urandom_range(0, 255), $urandom_range(0, 255));
            end else if (pick < 88) begin
                add_item(MODE_LOAD, $urandom_range(0, 255), key_pos());
            end else if (pick < 93) begin
                add_sched();
            end else begin
                add_item(MODE_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255));
            end
        end
    endtask

    task automatic drain();
        while (item_q.size() > 0 || ks_due_q.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_key_len(input logic [KLW-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sched_len = v;
        gen_len = v;
        n_cfg++;
    endtask

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    t_ks_item cur;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                cur = item_q.pop_front();
                ks_due_q.insert(ks_due_q.size(), rc4_advance(cur));
                n_items++;
                case (cur.mode)
                    MODE_LOAD:   n_load++;
                    MODE_SCHED:  n_sched++;
                    MODE_STREAM: n_stream++;
                    default:     n_unused++;
                endcase
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (i_s_tvalid && !o_s_tready) begin
                // hold the offered word
            end else if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (item_q.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {item_q[0].key_index, item_q[0].key_byte};
                i_s_tuser <= item_q[0].mode;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern plus one long hold-off
    logic [15:0] ready_pat = 16'hffff;
    int          pat_age = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    t_ks_word    want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                n_words++;
                if (ks_due_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word %0d: byte %02h flag %0b",
                                 n_words, o_m_tdata, o_m_tuser);
                end else begin
                    want = ks_due_q.pop_front();
                    if (o_m_tdata !== want.stream_byte || o_m_tuser !== want.stream_valid) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch on word %0d: expected byte %02h flag %0b, ",
                                      "got byte %02h flag %0b"},
                                     n_words, want.stream_byte, want.stream_valid,
                                     o_m_tdata, o_m_tuser);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (!hold_done && n_words >= 150 && item_q.size() > 20) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else begin
                if (pat_age == 0)
                    ready_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
                pat_age = (pat_age + 1) % 32;
                ready_pat = {ready_pat[0], ready_pat[15:1]};
                i_m_tready <= ready_pat[0];
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d items waiting, %0d words due",
                     idle_cycles, item_q.size(), ks_due_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    logic [KLW-1:0] len_plan [8];

    initial begin
        for (int k = 0; k < STATE_SIZE; k++)
            perm[k] = t_byte'(k);
        len_plan = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd2, 9'd255, 9'd257, 9'd16};
        len_plan[7] = 9'($urandom_range(3, 254));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // keystream from the reset permutation, unused mode, key extremes
        repeat (3) add_item(MODE_STREAM, 0, 0);
        add_item(MODE_UNUSED, 255, 255);
        add_item(MODE_LOAD, 255, 255);
        add_item(MODE_LOAD, 0, 0);
        add_sched();
        repeat (3) add_item(MODE_STREAM, 255, 255);
        add_item(MODE_UNUSED, 0, 0);
        add_item(MODE_STREAM, 0, 255);

        for (int p = 0; p < 8; p++) begin
            write_key_len(len_plan[p]);
            gen_phase(PHASE_ITEMS);
        end
        drain();
        repeat (10) @(posedge i_clk);

        $display("run covered %0d items: %0d keystream, %0d key schedules, %0d key loads",
                 n_items, n_stream, n_sched, n_load);
        $display("%0d unused mode items, %0d key length writes incl. 0, 1, 256 and 511",
                 n_unused, n_cfg);
        $display("%0d words checked, %0d errors", n_words, errors + ks_due_q.size());
        if (errors == 0 && ks_due_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rc4ks_pkg.sv
hw/rtl/rc4ks_perm_mem.sv
hw/rtl/rc4ks_key_mem.sv
hw/rtl/rc4_keystream_generator_top.sv
hw/rtl/rc4ks_checker.sv
sim/tb_rc4_keystream_generator_top.sv
